// ----- sv/line_follow_steering_control_defines.svh -----
// assertion macros for the line follow steering control block
`ifndef LINE_FOLLOW_STEERING_CONTROL_DEFINES_SVH
`define LINE_FOLLOW_STEERING_CONTROL_DEFINES_SVH

// same-cycle implication check, off while reset is low
`define LFSC_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// value within inclusive bounds whenever the condition holds, off while reset is low
`define LFSC_RANGE(lbl, ante, val, lo, hi, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (((val) >= (lo)) && ((val) <= (hi)))) else $error(msg);

`endif

// ----- sv/lfsc_pkg.sv -----
// shared types and constants for the line follow steering control block
package lfsc_pkg;

  localparam int unsigned LAT_W      = 16;
  localparam int unsigned CMD_W      = 11;
  localparam int unsigned SPEED_W    = 10;
  localparam int unsigned BAND_W     = 15;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned LIMIT_W    = 10;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 32;

  // gain products and the reciprocal scaling by 1/1000
  localparam int unsigned PROD_W      = 32;
  localparam int unsigned SCALED_W    = 20;
  localparam int unsigned RECIP_W     = 21;
  localparam int unsigned RECIP_SHIFT = 30;
  localparam int unsigned GAIN_SCALE  = 1000;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 21'd1073742;

  // forward ramp divider
  localparam int unsigned DIVIDEND_W = 25;
  localparam int unsigned DIVISOR_W  = 15;
  localparam int unsigned QUOT_W     = 10;
  localparam int unsigned DIV_BITS   = 2;
  localparam int unsigned DIV_STAGES = 5;

  typedef enum logic [IDX_W-1:0] {
    REG_HD_BAND   = 3'd0,
    REG_LT_BAND   = 3'd1,
    REG_YAW_GAIN  = 3'd2,
    REG_SIDE_GAIN = 3'd3,
    REG_TURN_LIM  = 3'd4,
    REG_STRAFE    = 3'd5,
    REG_CRUISE    = 3'd6,
    REG_CORNER    = 3'd7
  } lfsc_reg_e;

  // deadbanded errors as sign and magnitude
  typedef struct packed {
    logic             search;
    logic             hd_neg;
    logic [LAT_W-1:0] hd_mag;
    logic             lt_neg;
    logic [LAT_W-1:0] lt_mag;
  } lfsc_front_t;

  // per item control that rides along the pipeline
  typedef struct packed {
    logic search;
    logic strafe_ok;
    logic le_db;
    logic ge_sl;
    logic ramp_neg;
    logic st_zero;
    logic st_neg;
  } lfsc_ctl_t;

endpackage

// ----- sv/lfsc_front.sv -----
// input stage: absolute value and deadband of both errors
module lfsc_front (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic                                kind_i,
  input  logic signed [lfsc_pkg::LAT_W-1:0]   lateral_i,
  input  logic signed [lfsc_pkg::LAT_W-1:0]   heading_i,
  input  logic        [lfsc_pkg::BAND_W-1:0]  hd_band_i,
  input  logic        [lfsc_pkg::BAND_W-1:0]  lt_band_i,
  output lfsc_pkg::lfsc_front_t               front_o
);
  import lfsc_pkg::*;

  logic [LAT_W-1:0] hd_abs, lt_abs;
  lfsc_front_t      front_d, front_q;

  always_comb begin
    hd_abs = heading_i[LAT_W-1] ? LAT_W'(-heading_i) : LAT_W'(heading_i);
    lt_abs = lateral_i[LAT_W-1] ? LAT_W'(-lateral_i) : LAT_W'(lateral_i);
    front_d.search = kind_i;
    front_d.hd_neg = heading_i[LAT_W-1];
    front_d.lt_neg = lateral_i[LAT_W-1];
    front_d.hd_mag = (hd_abs < {1'b0, hd_band_i}) ? '0 : hd_abs;
    front_d.lt_mag = (lt_abs < {1'b0, lt_band_i}) ? '0 : lt_abs;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      front_q <= front_d;
    end
  end

  assign front_o = front_q;

endmodule

// ----- sv/lfsc_gain_clamp.sv -----
// gain multiply, divide by 1000 toward zero and symmetric clamp, four stages
module lfsc_gain_clamp (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic        [lfsc_pkg::LAT_W-1:0]   mag_i,
  input  logic                                neg_i,
  input  logic        [lfsc_pkg::GAIN_W-1:0]  gain_i,
  input  logic        [lfsc_pkg::LIMIT_W-1:0] lim_i,
  output logic signed [lfsc_pkg::CMD_W-1:0]   cmd_o
);
  import lfsc_pkg::*;

  logic [PROD_W-1:0]           prod_q;
  logic [PROD_W-1:0]           thresh;
  logic [2:0]                  neg_q;
  logic                        clamp_q, clamp2_q;
  logic [SCALED_W-1:0]         scaled_q;
  logic [SCALED_W+RECIP_W-1:0] recip_q;
  logic [LIMIT_W-1:0]          quot, mag_sel;
  logic [CMD_W-1:0]            mag_ext;
  logic signed [CMD_W-1:0]     cmd_d, cmd_q;

  // product at or above (lim+1)*1000 means the quotient exceeds the limit
  assign thresh = (PROD_W'(lim_i) + PROD_W'(1)) * PROD_W'(GAIN_SCALE);

  always_comb begin
    quot    = recip_q[RECIP_SHIFT +: LIMIT_W];
    mag_sel = clamp2_q ? lim_i : quot;
    mag_ext = CMD_W'(mag_sel);
    cmd_d   = neg_q[2] ? -mag_ext : mag_ext;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q   <= PROD_W'(gain_i) * PROD_W'(mag_i);
      neg_q    <= {neg_q[1:0], neg_i};
      clamp_q  <= prod_q >= thresh;
      scaled_q <= prod_q[SCALED_W-1:0];
      clamp2_q <= clamp_q;
      recip_q  <= (SCALED_W+RECIP_W)'(scaled_q) * (SCALED_W+RECIP_W)'(RECIP_1000);
      cmd_q    <= cmd_d;
    end
  end

  assign cmd_o = cmd_q;

endmodule

// ----- sv/lfsc_div_stage.sv -----
// one restoring division stage, two quotient bits per register
module lfsc_div_stage #(
  parameter int unsigned STAGE = 0
) (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic [lfsc_pkg::DIVIDEND_W-1:0]        rem_i,
  input  logic [lfsc_pkg::DIVISOR_W-1:0]         dvs_i,
  input  logic [lfsc_pkg::QUOT_W-1:0]            quot_i,
  output logic [lfsc_pkg::DIVIDEND_W-1:0]        rem_o,
  output logic [lfsc_pkg::DIVISOR_W-1:0]         dvs_o,
  output logic [lfsc_pkg::QUOT_W-1:0]            quot_o
);
  import lfsc_pkg::*;

  localparam int unsigned TOP_BIT = QUOT_W - 1 - DIV_BITS * STAGE;

  logic [DIVIDEND_W-1:0] rem_d, rem_q, shifted;
  logic [QUOT_W-1:0]     quot_d, quot_q;
  logic [DIVISOR_W-1:0]  dvs_q;

  always_comb begin
    rem_d   = rem_i;
    quot_d  = quot_i;
    shifted = '0;
    for (int k = 0; k < DIV_BITS; k++) begin
      shifted = DIVIDEND_W'(dvs_i) << (TOP_BIT - k);
      if (rem_d >= shifted) begin
        rem_d               = rem_d - shifted;
        quot_d[TOP_BIT - k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      dvs_q  <= dvs_i;
      quot_q <= quot_d;
    end
  end

  assign rem_o  = rem_q;
  assign dvs_o  = dvs_q;
  assign quot_o = quot_q;

endmodule

// ----- sv/line_follow_steering_control.sv -----
// top level of the line follow steering control pipeline
// Proportional steering law for a line tracker: each transfer carries a mode bit
// and the signed lateral and heading errors, and yields one transfer holding turn,
// sideways and forward commands. The block takes one transfer per clock while the
// output slot is free or being taken; the pipeline depth is set by the four stage
// gain path (multiply, limit compare, reciprocal multiply for the divide by 1000,
// sign) and by the five stage restoring divider of the forward speed ramp. The
// whole pipeline moves as one: it advances whenever the output register is empty
// or its result is taken, so up to eight items are in flight. Configuration
// registers are written through cfg_we_i/cfg_idx_i/cfg_data_i and must only change
// while no item is in flight.
`include "line_follow_steering_control_defines.svh"

module line_follow_steering_control #(
  parameter int unsigned SIDEWAYS_LIMIT = 1000
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [lfsc_pkg::IDX_W-1:0]         cfg_idx_i,
  input  logic [lfsc_pkg::CFG_W-1:0]         cfg_data_i,
  // measurement stream
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [lfsc_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,   // lateral, heading
  input  logic                               s_axis_tuser_i,   // kind
  // command stream
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [lfsc_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o    // turn, sideways, forward
);
  import lfsc_pkg::*;

  localparam int unsigned LAST = 8;
  localparam logic signed [CMD_W-1:0] SIDE_LIM = CMD_W'(SIDEWAYS_LIMIT);

  // configuration registers
  logic [BAND_W-1:0]  hd_band_q, lt_band_q, strafe_q;
  logic [GAIN_W-1:0]  yaw_gain_q, side_gain_q;
  logic [LIMIT_W-1:0] turn_lim_q;
  logic [SPEED_W-1:0] cruise_q, corner_q;

  // pipeline control
  logic [LAST:1] vld_q;
  logic          adv;

  lfsc_front_t   front;
  lfsc_ctl_t     ctl_d;
  lfsc_ctl_t     ctl_q [2:7];

  // ramp setup
  logic [SPEED_W-1:0]    diff;
  logic [BAND_W-1:0]     dm;
  logic [DIVIDEND_W-1:0] dividend_q;
  logic [DIVISOR_W-1:0]  divisor_q;

  logic [DIVIDEND_W-1:0] rem_w  [DIV_STAGES+1];
  logic [DIVISOR_W-1:0]  dvs_w  [DIV_STAGES+1];
  logic [QUOT_W-1:0]     quot_w [DIV_STAGES+1];

  logic signed [CMD_W-1:0] turn_s5, side_s5;
  logic signed [CMD_W-1:0] turn_q [6:7];
  logic signed [CMD_W-1:0] side_q [6:7];

  // output register
  logic signed [CMD_W-1:0] turn_d, side_d, turn_out_q, side_out_q;
  logic [SPEED_W-1:0]      fwd_d, fwd_out_q;
  logic                    search_out_q;
  logic [CMD_W-1:0]        tl_ext;
  logic [SPEED_W-1:0]      fwd_lo, fwd_hi;
  logic signed [CMD_W-1:0] tl_s;
  logic                    follow_out;

  // one shared stall: everything moves when the output slot frees up
  assign adv             = !vld_q[LAST] || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign m_axis_tvalid_o = vld_q[LAST];
  assign m_axis_tdata_o  = {fwd_out_q, side_out_q, turn_out_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hd_band_q   <= BAND_W'(5);
      lt_band_q   <= BAND_W'(5);
      yaw_gain_q  <= GAIN_W'(1000);
      side_gain_q <= GAIN_W'(1000);
      turn_lim_q  <= LIMIT_W'(500);
      strafe_q    <= BAND_W'(30);
      cruise_q    <= SPEED_W'(400);
      corner_q    <= SPEED_W'(200);
    end else if (cfg_we_i) begin
      unique case (lfsc_reg_e'(cfg_idx_i))
        REG_HD_BAND:   hd_band_q   <= cfg_data_i[BAND_W-1:0];
        REG_LT_BAND:   lt_band_q   <= cfg_data_i[BAND_W-1:0];
        REG_YAW_GAIN:  yaw_gain_q  <= cfg_data_i[GAIN_W-1:0];
        REG_SIDE_GAIN: side_gain_q <= cfg_data_i[GAIN_W-1:0];
        REG_TURN_LIM:  turn_lim_q  <= cfg_data_i[LIMIT_W-1:0];
        REG_STRAFE:    strafe_q    <= cfg_data_i[BAND_W-1:0];
        REG_CRUISE:    cruise_q    <= cfg_data_i[SPEED_W-1:0];
        REG_CORNER:    corner_q    <= cfg_data_i[SPEED_W-1:0];
      endcase
    end
  end

  // valid bits ride with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAST-1:1], s_axis_tvalid_i};
    end
  end

  // stage 1: deadband
  lfsc_front u_front (
    .clk_i     (clk_i),
    .en_i      (adv),
    .kind_i    (s_axis_tuser_i),
    .lateral_i (s_axis_tdata_i[LAT_W-1:0]),
    .heading_i (s_axis_tdata_i[2*LAT_W-1:LAT_W]),
    .hd_band_i (hd_band_q),
    .lt_band_i (lt_band_q),
    .front_o   (front)
  );

  // stages 2 to 5: turn and sideways gain paths
  lfsc_gain_clamp u_turn (
    .clk_i  (clk_i),
    .en_i   (adv),
    .mag_i  (front.hd_mag),
    .neg_i  (!front.hd_neg),       // positive heading turns right, negative command
    .gain_i (yaw_gain_q),
    .lim_i  (turn_lim_q),
    .cmd_o  (turn_s5)
  );

  lfsc_gain_clamp u_side (
    .clk_i  (clk_i),
    .en_i   (adv),
    .mag_i  (front.lt_mag),
    .neg_i  (front.lt_neg),
    .gain_i (side_gain_q),
    .lim_i  (LIMIT_W'(SIDEWAYS_LIMIT)),
    .cmd_o  (side_s5)
  );

  // stage 2: heading bands, ramp operands and search direction
  always_comb begin
    ctl_d.search    = front.search;
    ctl_d.le_db     = front.hd_mag <= {1'b0, hd_band_q};
    ctl_d.ge_sl     = front.hd_mag >= {1'b0, strafe_q};
    ctl_d.strafe_ok = !ctl_d.ge_sl;
    ctl_d.ramp_neg  = corner_q > cruise_q;
    // search: heading sign wins, lateral sign is the fallback
    ctl_d.st_zero   = (front.hd_mag == '0) && (front.lt_mag == '0);
    ctl_d.st_neg    = (front.hd_mag != '0) ? !front.hd_neg : !front.lt_neg;
    diff            = ctl_d.ramp_neg ? (corner_q - cruise_q) : (cruise_q - corner_q);
    // only meaningful inside the ramp, where it fits the band width
    dm              = BAND_W'(front.hd_mag - {1'b0, hd_band_q});
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctl_q[2]   <= ctl_d;
      for (int k = 3; k <= 7; k++) begin
        ctl_q[k] <= ctl_q[k-1];
      end
      dividend_q <= DIVIDEND_W'(diff) * DIVIDEND_W'(dm);
      divisor_q  <= strafe_q - hd_band_q;
      turn_q[6]  <= turn_s5;
      side_q[6]  <= side_s5;
      turn_q[7]  <= turn_q[6];
      side_q[7]  <= side_q[6];
    end
  end

  // stages 3 to 7: ramp quotient, which stays below the speed difference
  assign rem_w[0]  = dividend_q;
  assign dvs_w[0]  = divisor_q;
  assign quot_w[0] = '0;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    lfsc_div_stage #(
      .STAGE (g)
    ) u_div (
      .clk_i  (clk_i),
      .en_i   (adv),
      .rem_i  (rem_w[g]),
      .dvs_i  (dvs_w[g]),
      .quot_i (quot_w[g]),
      .rem_o  (rem_w[g+1]),
      .dvs_o  (dvs_w[g+1]),
      .quot_o (quot_w[g+1])
    );
  end

  // stage 8: final selection into the output register
  always_comb begin
    tl_ext = CMD_W'(turn_lim_q);
    if (ctl_q[7].search) begin
      turn_d = ctl_q[7].st_zero ? '0 : (ctl_q[7].st_neg ? -tl_ext : tl_ext);
      side_d = '0;
      fwd_d  = '0;
    end else begin
      turn_d = turn_q[7];
      side_d = ctl_q[7].strafe_ok ? side_q[7] : '0;
      priority if (ctl_q[7].le_db) begin
        fwd_d = cruise_q;
      end else if (ctl_q[7].ge_sl) begin
        fwd_d = corner_q;
      end else if (ctl_q[7].ramp_neg) begin
        fwd_d = SPEED_W'(cruise_q + quot_w[DIV_STAGES]);
      end else begin
        fwd_d = SPEED_W'(cruise_q - quot_w[DIV_STAGES]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      turn_out_q   <= turn_d;
      side_out_q   <= side_d;
      fwd_out_q    <= fwd_d;
      search_out_q <= ctl_q[7].search;
    end
  end

  // bounds for the output range checks
  always_comb begin
    fwd_lo     = (corner_q < cruise_q) ? corner_q : cruise_q;
    fwd_hi     = (corner_q < cruise_q) ? cruise_q : corner_q;
    tl_s       = $signed(tl_ext);
    follow_out = vld_q[LAST] && !search_out_q;
  end

  `LFSC_RANGE(a_turn_in_limit, vld_q[LAST], turn_out_q, -tl_s, tl_s, "turn beyond limit")
  `LFSC_RANGE(a_side_in_limit, vld_q[LAST], side_out_q, -SIDE_LIM, SIDE_LIM, "side beyond limit")
  `LFSC_RANGE(a_fwd_in_ramp, follow_out, fwd_out_q, fwd_lo, fwd_hi, "forward outside ramp")
  `LFSC_ASSERT(a_ready_empty, !vld_q[LAST], s_axis_tready_o, "input stalled while output empty")

endmodule
